### rtl/dmm_pkg.sv
// shared types, codes and helpers of the dense matrix multiply block
`default_nettype none
package dmm_pkg;

    localparam int DIM_W  = 4;
    localparam int IDX_W  = 3;
    localparam int VAL_W  = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 35;

    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    localparam logic [1:0] CFG_A_ROWS    = 2'd0;
    localparam logic [1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [1:0] CFG_B_COLS    = 2'd2;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_k;
        logic             last_elem;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } issue_t;

    // zero counts as one, anything above the limit is clamped to it
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r,
                                                 input logic [5:0] lim);
        logic [DIM_W-1:0] res;
        if (r == '0) begin
            res = DIM_W'(1);
        end else if ({2'b00, r} > lim) begin
            res = lim[DIM_W-1:0];
        end else begin
            res = r;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### rtl/dmm_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none
module dmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### rtl/dmm_seq.sv
// command decode, store writes and read sequencing over rows, columns and inner index
`default_nettype none
module dmm_seq #(
    parameter int MAX_DIM = 8,
    parameter int AW      = 6
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [1:0]                  s_tuser,
    input  wire logic [23:0]                 s_tdata,
    input  wire logic [dmm_pkg::DIM_W-1:0]   a_rows,
    input  wire logic [dmm_pkg::DIM_W-1:0]   inner_dim,
    input  wire logic [dmm_pkg::DIM_W-1:0]   b_cols,
    input  wire logic                        result_moved,
    output logic                             a_we,
    output logic                             b_we,
    output logic [AW-1:0]                    waddr,
    output logic [dmm_pkg::VAL_W-1:0]        wdata,
    output logic [AW-1:0]                    a_raddr,
    output logic [AW-1:0]                    b_raddr,
    output dmm_pkg::issue_t                  issue
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [dmm_pkg::DIM_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [dmm_pkg::DIM_W-1:0] nr, nk, nc;
    logic [dmm_pkg::IDX_W-1:0] ld_row, ld_col;
    logic                      accept, in_range;

    assign nr = dmm_pkg::eff_dim(a_rows, 6'(MAX_DIM));
    assign nk = dmm_pkg::eff_dim(inner_dim, 6'(MAX_DIM));
    assign nc = dmm_pkg::eff_dim(b_cols, 6'(MAX_DIM));

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign ld_row   = s_tdata[2:0];
    assign ld_col   = s_tdata[5:3];
    assign wdata    = s_tdata[21:6];
    assign in_range = ({29'd0, ld_row} < 32'(MAX_DIM)) && ({29'd0, ld_col} < 32'(MAX_DIM));
    assign waddr    = AW'(ld_row) * AW'(MAX_DIM) + AW'(ld_col);
    assign a_we     = accept && in_range && (s_tuser == dmm_pkg::CMD_LOAD_A);
    assign b_we     = accept && in_range && (s_tuser == dmm_pkg::CMD_LOAD_B);

    assign a_raddr  = AW'(i_reg) * AW'(MAX_DIM) + AW'(k_reg);
    assign b_raddr  = AW'(k_reg) * AW'(MAX_DIM) + AW'(j_reg);

    assign issue.valid     = (state_reg == ST_RUN);
    assign issue.first     = (k_reg == '0);
    assign issue.last_k    = (k_reg == nk - 1'b1);
    assign issue.last_elem = (i_reg == nr - 1'b1) && (j_reg == nc - 1'b1);
    assign issue.row       = i_reg[dmm_pkg::IDX_W-1:0];
    assign issue.col       = j_reg[dmm_pkg::IDX_W-1:0];

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_tuser == dmm_pkg::CMD_COMPUTE)) begin
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (k_reg == nk - 1'b1) begin
                    k_next     = '0;
                    state_next = ST_WAIT;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_WAIT: begin
                // next element starts once the finished sum has left the accumulator
                if (result_moved) begin
                    if (j_reg == nc - 1'b1) begin
                        j_next = '0;
                        if (i_reg == nr - 1'b1) begin
                            state_next = ST_IDLE;
                        end else begin
                            i_next     = i_reg + 1'b1;
                            state_next = ST_RUN;
                        end
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_RUN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

endmodule
`default_nettype wire

### rtl/dmm_mac.sv
// multiply-accumulate pipeline and result output register
`default_nettype none
module dmm_mac (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire dmm_pkg::issue_t            issue,
    input  wire logic [dmm_pkg::VAL_W-1:0]  a_rdata,
    input  wire logic [dmm_pkg::VAL_W-1:0]  b_rdata,
    output logic                            result_moved,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [47:0]                     m_tdata,
    output logic                            m_tlast
);

    dmm_pkg::issue_t s1_reg, s2_reg;
    logic signed [dmm_pkg::PROD_W-1:0] prod_reg;
    logic signed [dmm_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic                              done_reg;
    logic [dmm_pkg::IDX_W-1:0]         done_row_reg, done_col_reg;
    logic                              done_last_reg;
    logic                              out_valid_reg;
    logic [dmm_pkg::IDX_W-1:0]         out_row_reg, out_col_reg;
    logic [dmm_pkg::ACC_W-1:0]         out_value_reg;
    logic                              out_last_reg;

    assign acc_next = (s2_reg.first ? '0 : acc_reg)
                    + {{(dmm_pkg::ACC_W - dmm_pkg::PROD_W){prod_reg[dmm_pkg::PROD_W-1]}},
                       prod_reg};

    assign result_moved = done_reg && (!out_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        s1_reg.first     <= issue.first;
        s1_reg.last_k    <= issue.last_k;
        s1_reg.last_elem <= issue.last_elem;
        s1_reg.row       <= issue.row;
        s1_reg.col       <= issue.col;
        s2_reg.first     <= s1_reg.first;
        s2_reg.last_k    <= s1_reg.last_k;
        s2_reg.last_elem <= s1_reg.last_elem;
        s2_reg.row       <= s1_reg.row;
        s2_reg.col       <= s1_reg.col;
        prod_reg         <= $signed(a_rdata) * $signed(b_rdata);
        if (s2_reg.valid) begin
            acc_reg <= acc_next;
        end
        if (s2_reg.valid && s2_reg.last_k) begin
            done_row_reg  <= s2_reg.row;
            done_col_reg  <= s2_reg.col;
            done_last_reg <= s2_reg.last_elem;
        end
        if (result_moved) begin
            out_row_reg   <= done_row_reg;
            out_col_reg   <= done_col_reg;
            out_value_reg <= acc_reg;
            out_last_reg  <= done_last_reg;
        end
        if (!aresetn) begin
            s1_reg.valid  <= 1'b0;
            s2_reg.valid  <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_reg.valid <= issue.valid;
            s2_reg.valid <= s1_reg.valid;
            if (s2_reg.valid && s2_reg.last_k) begin
                done_reg <= 1'b1;
            end else if (result_moved) begin
                done_reg <= 1'b0;
            end
            if (result_moved) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_value_reg, out_col_reg, out_row_reg};
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

### rtl/dense_matrix_multiply.sv
// top level of the dense matrix multiply block: registers, stores, sequencer and mac
//
// channel  direction  handshake            payload
// s_       in         s_tvalid / s_tready  s_tuser cmd, s_tdata row, col, value
// m_       out        m_tvalid / m_tready  m_tdata out_row, out_col, out_value, m_tlast
// cfg_     in         cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// a load item writes one entry of the a or b store
// a compute item runs a_rows * b_cols elements: one store
// read per inner step, then the read, multiply and accumulate stages per element
// s_tready is low for the whole compute; results wait in the output register
// while m_tready is low, which holds back the next element's reads
// aresetn resets registers to 8 x 8 x 8; the stores are not cleared
`default_nettype none
module dense_matrix_multiply #(
    parameter int MAX_DIM = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,   // cmd
    input  wire logic [23:0] s_tdata,   // row[2:0], col[5:3], value[21:6]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // out_row[2:0], out_col[5:3], out_value[40:6]
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [3:0]  cfg_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    logic [dmm_pkg::DIM_W-1:0] a_rows_reg, inner_dim_reg, b_cols_reg;
    logic                      a_we, b_we, result_moved;
    logic [AW-1:0]             waddr, a_raddr, b_raddr;
    logic [dmm_pkg::VAL_W-1:0] wdata, a_rdata, b_rdata;
    dmm_pkg::issue_t           issue;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_rows_reg    <= dmm_pkg::DIM_W'(8);
            inner_dim_reg <= dmm_pkg::DIM_W'(8);
            b_cols_reg    <= dmm_pkg::DIM_W'(8);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                dmm_pkg::CFG_A_ROWS:    a_rows_reg    <= cfg_data;
                dmm_pkg::CFG_INNER_DIM: inner_dim_reg <= cfg_data;
                dmm_pkg::CFG_B_COLS:    b_cols_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    dmm_seq #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .a_rows       (a_rows_reg),
        .inner_dim    (inner_dim_reg),
        .b_cols       (b_cols_reg),
        .result_moved (result_moved),
        .a_we         (a_we),
        .b_we         (b_we),
        .waddr        (waddr),
        .wdata        (wdata),
        .a_raddr      (a_raddr),
        .b_raddr      (b_raddr),
        .issue        (issue)
    );

    dmm_ram #(
        .WIDTH (dmm_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_a_store (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    dmm_ram #(
        .WIDTH (dmm_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_b_store (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    dmm_mac u_mac (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .issue        (issue),
        .a_rdata      (a_rdata),
        .b_rdata      (b_rdata),
        .result_moved (result_moved),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule
`default_nettype wire
